### sv/fpe_pkg.sv
// shared types and constants for the fifo slot pool
// controller state, command and status structs between controller and datapath
// no dependencies
package fpe_pkg;

   localparam int ID_W   = 64;
   localparam int BUSY_W = 8;
   localparam int SLOT_W = 3;
   localparam int CAP_W  = 4;

   localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_SCAN   = 7'b0000010,
      ST_CHECK  = 7'b0000100,
      ST_EVICT  = 7'b0001000,
      ST_FETCH  = 7'b0010000,
      ST_INSERT = 7'b0100000,
      ST_RESP   = 7'b1000000
   } state_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic set_hit;
      logic set_err;
      logic evict;
      logic fetch;
      logic insert;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic found;
      logic no_room;
      logic need_zero;
      logic evict_last;
   } status_type;

endpackage

### sv/fpe_ctrl.sv
// request sequencer for the fifo slot pool
// drives datapath commands from datapath status; uses fpe_pkg
module fpe_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                rsp_stall,
   input  fpe_pkg::status_type status,
   output fpe_pkg::cmd_type    cmd,
   output logic                req_stall,
   output logic                rsp_valid
);
   import fpe_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            priority if (status.found) begin
               cmd.set_hit = 1'b1;
               state_in    = ST_RESP;
            end else if (status.no_room) begin
               cmd.set_err = 1'b1;
               state_in    = ST_RESP;
            end else if (status.need_zero) begin
               state_in = ST_INSERT;
            end else begin
               state_in = ST_EVICT;
            end
         end
         ST_EVICT: begin
            cmd.evict = 1'b1;
            if (status.evict_last) state_in = ST_FETCH;
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_INSERT;
         end
         ST_INSERT: begin
            cmd.insert = 1'b1;
            state_in   = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);

endmodule

### sv/fpe_dpath.sv
// datapath of the fifo slot pool: key memory, valid bits, age cells,
// lookup scan, rank pass for eviction and result registers; uses fpe_pkg
module fpe_dpath #(
   parameter int ENTRIES  = 8,
   parameter int KEY_BITS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fpe_pkg::cmd_type              cmd,
   output fpe_pkg::status_type           status,
   input  logic [fpe_pkg::CAP_W-1:0]     capacity,
   input  logic [fpe_pkg::ID_W-1:0]      req_config_id,
   input  logic [fpe_pkg::BUSY_W-1:0]    req_busy_mask,
   output logic [fpe_pkg::SLOT_W-1:0]    rsp_slot,
   output logic                          rsp_hit,
   output logic                          rsp_created,
   output logic                          rsp_evicted,
   output logic [fpe_pkg::ID_W-1:0]      rsp_evicted_id,
   output logic                          rsp_full_error
);
   import fpe_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam logic [IDX_W-1:0] LAST  = IDX_W'(ENTRIES - 1);
   localparam logic [CMP_W-1:0] ENT_C = CMP_W'(ENTRIES);

   // storage
   logic [KEY_BITS-1:0] key_mem [ENTRIES];
   logic [ENTRIES-1:0]  valid_ff;
   logic [IDX_W-1:0]    age_ff [ENTRIES];
   logic [CNT_W-1:0]    count_ff;

   // request
   logic [KEY_BITS-1:0] key_ff;
   logic [ENTRIES-1:0]  held_ff;

   // scan
   logic [IDX_W-1:0]    scan_idx_ff;
   logic                issue_on_ff;
   logic                cmp_live_ff;
   logic [IDX_W-1:0]    cmp_idx_ff;
   logic [KEY_BITS-1:0] rd_data_ff;
   logic                found_ff;
   logic [IDX_W-1:0]    hit_idx_ff;
   logic [CNT_W-1:0]    unheld_ff;
   logic                free_any_ff;
   logic [IDX_W-1:0]    free_idx_ff;

   // rank pass
   logic [IDX_W-1:0]    rank_ff;
   logic [CNT_W-1:0]    ev_cnt_ff;
   logic [IDX_W-1:0]    first_vic_ff;
   logic [IDX_W-1:0]    min_vic_ff;

   // results
   logic [SLOT_W-1:0]   res_slot_ff;
   logic                res_hit_ff;
   logic                res_created_ff;
   logic                res_evicted_ff;
   logic [ID_W-1:0]     res_evicted_id_ff;
   logic                res_err_ff;

   logic [CMP_W-1:0]    cap_ext;
   logic [CMP_W-1:0]    cap_clamp;
   logic [CNT_W-1:0]    eff_cap;
   logic [CNT_W-1:0]    need;
   logic [IDX_W-1:0]    rd_addr;
   logic [ENTRIES-1:0]  match;
   logic                cand_hit;
   logic                evict_now;
   logic [IDX_W-1:0]    vic_idx;
   logic                any_evicted;
   logic [IDX_W-1:0]    free_slot;
   logic [CNT_W-1:0]    count_kept;

   always_comb begin
      cap_ext = CMP_W'(capacity);
      priority if (cap_ext == '0) begin
         cap_clamp = CMP_W'(1);
      end else if (cap_ext > ENT_C) begin
         cap_clamp = ENT_C;
      end else begin
         cap_clamp = cap_ext;
      end
      eff_cap = CNT_W'(cap_clamp);
      need    = (count_ff >= eff_cap) ? CNT_W'(count_ff - eff_cap + CNT_W'(1)) : '0;
   end

   // one age cell per slot; live ages are distinct ranks, so at most one matches
   always_comb begin
      vic_idx = '0;
      for (int j = 0; j < ENTRIES; j++) begin
         match[j] = valid_ff[j] && (age_ff[j] == rank_ff);
         if (match[j]) vic_idx = vic_idx | IDX_W'(j);
      end
      cand_hit  = |(match & ~held_ff);
      evict_now = cand_hit && (ev_cnt_ff < need);
   end

   assign any_evicted = (ev_cnt_ff != '0);
   assign count_kept  = CNT_W'(count_ff - ev_cnt_ff);
   // lowest free slot: first empty one seen in the scan or the lowest one just freed
   assign free_slot = (any_evicted && (!free_any_ff || (min_vic_ff < free_idx_ff)))
                      ? min_vic_ff : free_idx_ff;
   assign rd_addr   = cmd.fetch ? first_vic_ff : scan_idx_ff;

   assign status.scan_done  = cmp_live_ff && (cmp_idx_ff == LAST);
   assign status.found      = found_ff;
   assign status.no_room    = (unheld_ff < need);
   assign status.need_zero  = (need == '0);
   assign status.evict_last = (CNT_W'(rank_ff) == CNT_W'(count_ff - CNT_W'(1)));

   // key memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (cmd.insert) key_mem[free_slot] <= key_ff;
      rd_data_ff <= key_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
      end else begin
         if (cmd.evict) begin
            for (int j = 0; j < ENTRIES; j++) begin
               if (match[j] && evict_now) valid_ff[j] <= 1'b0;
            end
         end
         if (cmd.insert) begin
            valid_ff[free_slot] <= 1'b1;
            count_ff            <= CNT_W'(count_kept + CNT_W'(1));
         end
      end
   end

   // survivors of the rank pass close the gaps left by evicted entries
   always_ff @(posedge clock) begin
      if (cmd.evict) begin
         for (int j = 0; j < ENTRIES; j++) begin
            if (match[j] && !evict_now) age_ff[j] <= IDX_W'(rank_ff - IDX_W'(ev_cnt_ff));
         end
      end
      if (cmd.insert) age_ff[free_slot] <= IDX_W'(count_kept);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_on_ff <= 1'b0;
         cmp_live_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            issue_on_ff <= 1'b1;
         end else if (cmd.scan && issue_on_ff && (scan_idx_ff == LAST)) begin
            issue_on_ff <= 1'b0;
         end
         cmp_live_ff <= cmd.scan && issue_on_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff      <= req_config_id[KEY_BITS-1:0];
         held_ff     <= ENTRIES'(req_busy_mask);
         scan_idx_ff <= '0;
         found_ff    <= 1'b0;
         hit_idx_ff  <= '0;
         unheld_ff   <= '0;
         free_any_ff <= 1'b0;
         free_idx_ff <= '0;
         rank_ff     <= '0;
         ev_cnt_ff   <= '0;
      end
      if (cmd.scan) begin
         if (issue_on_ff) begin
            scan_idx_ff <= IDX_W'(scan_idx_ff + IDX_W'(1));
            if (valid_ff[scan_idx_ff] && !held_ff[scan_idx_ff]) begin
               unheld_ff <= CNT_W'(unheld_ff + CNT_W'(1));
            end
            if (!valid_ff[scan_idx_ff] && !free_any_ff) begin
               free_any_ff <= 1'b1;
               free_idx_ff <= scan_idx_ff;
            end
         end
         if (cmp_live_ff && !found_ff && valid_ff[cmp_idx_ff] && (rd_data_ff == key_ff)) begin
            found_ff   <= 1'b1;
            hit_idx_ff <= cmp_idx_ff;
         end
      end
      cmp_idx_ff <= scan_idx_ff;
      if (cmd.evict) begin
         rank_ff <= IDX_W'(rank_ff + IDX_W'(1));
         if (evict_now) begin
            ev_cnt_ff <= CNT_W'(ev_cnt_ff + CNT_W'(1));
            if (!any_evicted) first_vic_ff <= vic_idx;
            if (!any_evicted || (vic_idx < min_vic_ff)) min_vic_ff <= vic_idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      priority if (cmd.set_hit) begin
         res_slot_ff       <= SLOT_W'(hit_idx_ff);
         res_hit_ff        <= 1'b1;
         res_created_ff    <= 1'b0;
         res_evicted_ff    <= 1'b0;
         res_evicted_id_ff <= '0;
         res_err_ff        <= 1'b0;
      end else if (cmd.set_err) begin
         res_slot_ff       <= '0;
         res_hit_ff        <= 1'b0;
         res_created_ff    <= 1'b0;
         res_evicted_ff    <= 1'b0;
         res_evicted_id_ff <= '0;
         res_err_ff        <= 1'b1;
      end else if (cmd.insert) begin
         res_slot_ff       <= SLOT_W'(free_slot);
         res_hit_ff        <= 1'b0;
         res_created_ff    <= 1'b1;
         res_evicted_ff    <= any_evicted;
         res_evicted_id_ff <= any_evicted ? ID_W'(rd_data_ff) : '0;
         res_err_ff        <= 1'b0;
      end else begin
         res_slot_ff <= res_slot_ff;
      end
   end

   assign rsp_slot       = res_slot_ff;
   assign rsp_hit        = res_hit_ff;
   assign rsp_created    = res_created_ff;
   assign rsp_evicted    = res_evicted_ff;
   assign rsp_evicted_id = res_evicted_id_ff;
   assign rsp_full_error = res_err_ff;

endmodule

### sv/fifo_pool_with_pinned_entries_core.sv
// Fully associative pool of ENTRIES keyed slots with oldest-first replacement
// that skips slots held by clients. One request is handled at a time: the key
// memory has a single read port and is scanned one slot per cycle. A hit then
// sets the result; a miss without eviction first inserts the key, and a miss
// that evicts first walks the stored entries rank by rank to pick victims and
// renumber ages, then reads the first victim's key and inserts. The result is
// held in an output register until taken; the next request is accepted after that.
// The capacity register may be written at any time the block is idle.
module fifo_pool_with_pinned_entries_core #(
   parameter int ENTRIES  = 8,
   parameter int KEY_BITS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [fpe_pkg::ID_W-1:0]      req_config_id,
   input  logic [fpe_pkg::BUSY_W-1:0]    req_busy_mask,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [fpe_pkg::SLOT_W-1:0]    rsp_slot,
   output logic                          rsp_hit,
   output logic                          rsp_created,
   output logic                          rsp_evicted,
   output logic [fpe_pkg::ID_W-1:0]      rsp_evicted_id,
   output logic                          rsp_full_error,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [fpe_pkg::CAP_W-1:0]     csr_capacity
);
   import fpe_pkg::*;

   logic [CAP_W-1:0] capacity_ff;
   cmd_type          cmd;
   status_type       status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (csr_valid && csr_ready) begin
         capacity_ff <= csr_capacity;
      end
   end

   fpe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid)
   );

   fpe_dpath #(
      .ENTRIES  (ENTRIES),
      .KEY_BITS (KEY_BITS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .capacity       (capacity_ff),
      .req_config_id  (req_config_id),
      .req_busy_mask  (req_busy_mask),
      .rsp_slot       (rsp_slot),
      .rsp_hit        (rsp_hit),
      .rsp_created    (rsp_created),
      .rsp_evicted    (rsp_evicted),
      .rsp_evicted_id (rsp_evicted_id),
      .rsp_full_error (rsp_full_error)
   );

endmodule
